@@ rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int COORD_BITS_DEF = 10;
    localparam int COST_BITS_DEF  = 16;

    // request kind, carried on the input tuser
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // result flags, carried on the output tuser
    localparam int FLAG_W = 3;

    typedef struct packed {
        logic load;        // latch the accepted word, clear result
        logic push_start;  // k <= occupancy, read tail entry
        logic shift;       // move entry k-1 up to k, read k-2
        logic put;         // write new entry at k, occupancy + 1
        logic pop_rd;      // read head entry
        logic pop_take;    // capture head, advance head, occupancy - 1
        logic qry_start;   // reset scan index
        logic qry_step;    // advance the scan, compare the entry read
        logic set_ovf;
        logic set_empty;
        logic emit;        // load output register
    } t_spq_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             empty;
        logic             full;
        logic             ge;        // read entry cost >= new cost
        logic             k_one;     // insert index is 1
        logic             qry_done;
        logic             out_free;
    } t_spq_sts;

endpackage

@@ rtl/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/spq_ctrl.sv @@
// Controller state machine for the sorted priority queue.
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  spq_pkg::t_spq_sts i_sts,
    output spq_pkg::t_spq_cmd o_cmd
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_PUT    = 3'd3;
    localparam logic [2:0] S_POPD   = 3'd4;
    localparam logic [2:0] S_QRY    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_spq_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.act)
                    ACT_PUSH: begin
                        if (i_sts.full) begin
                            cmd.set_ovf = 1'b1;
                            n_state     = S_EMIT;
                        end else begin
                            cmd.push_start = 1'b1;
                            n_state        = i_sts.empty ? S_PUT : S_SHIFT;
                        end
                    end
                    ACT_POP: begin
                        if (i_sts.empty) begin
                            cmd.set_empty = 1'b1;
                            n_state       = S_EMIT;
                        end else begin
                            cmd.pop_rd = 1'b1;
                            n_state    = S_POPD;
                        end
                    end
                    ACT_QUERY: begin
                        cmd.qry_start = 1'b1;
                        n_state       = S_QRY;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_SHIFT: begin
                // walk down from the tail, moving entries that are not cheaper
                if (i_sts.ge) begin
                    cmd.shift = 1'b1;
                    n_state   = i_sts.k_one ? S_PUT : S_SHIFT;
                end else begin
                    cmd.put = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_PUT: begin
                cmd.put = 1'b1;
                n_state = S_EMIT;
            end
            S_POPD: begin
                cmd.pop_take = 1'b1;
                n_state      = S_EMIT;
            end
            S_QRY: begin
                cmd.qry_step = 1'b1;
                if (i_sts.qry_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

@@ rtl/spq_dp.sv @@
// Datapath: circular sorted entry store, counters, result and output registers.
`timescale 1ns / 1ps

module spq_dp #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int COORD_BITS = spq_pkg::COORD_BITS_DEF,
    parameter int COST_BITS  = spq_pkg::COST_BITS_DEF,
    localparam int IN_W  = ((2 * COORD_BITS + COST_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spq_pkg::t_spq_cmd          i_cmd,
    output spq_pkg::t_spq_sts          o_sts,
    input  logic [IN_W-1:0]            i_s_tdata,
    input  logic [spq_pkg::ACT_W-1:0]  i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [OUT_W-1:0]           o_m_tdata,
    output logic [spq_pkg::FLAG_W-1:0] o_m_tuser
);
    import spq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int EW = 2 * COORD_BITS + COST_BITS;

    // latched request
    logic [ACT_W-1:0]      r_act;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic [COST_BITS-1:0]  r_cost;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] r_k;      // insert slot for push, scan index for query
    logic          r_pend;   // a scan read is in flight

    logic [COORD_BITS-1:0] r_res_x;
    logic [COORD_BITS-1:0] r_res_y;
    logic                  r_res_present;
    logic                  r_res_empty;
    logic                  r_res_ovf;

    logic                  r_m_valid;
    logic [OUT_W-1:0]      r_m_tdata;
    logic [FLAG_W-1:0]     r_m_tuser;

    logic [CW-1:0]         rd_l;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic                  we;
    logic [EW-1:0]         wdata;
    logic [EW-1:0]         rdata;
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [COST_BITS-1:0]  rd_cost;
    logic                  hit_now;
    logic                  empty;
    logic                  full;

    // logical position from the head to a physical address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(l);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign empty = (r_occ == '0);
    assign full  = (r_occ == CW'(DEPTH));

    assign rd_x    = rdata[COORD_BITS-1:0];
    assign rd_y    = rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_cost = rdata[EW-1:2*COORD_BITS];
    assign hit_now = r_pend && (rd_x == r_x) && (rd_y == r_y);

    always_comb begin
        rd_l = '0;
        priority if (i_cmd.push_start) begin
            rd_l = empty ? '0 : r_occ - CW'(1);
        end else if (i_cmd.shift) begin
            rd_l = (r_k == CW'(1)) ? '0 : r_k - CW'(2);
        end else if (i_cmd.qry_step) begin
            rd_l = (r_k < r_occ) ? r_k : '0;
        end else begin
            rd_l = '0;
        end
    end

    assign raddr = phys(r_head, rd_l);
    assign waddr = phys(r_head, r_k);
    assign we    = i_cmd.shift | i_cmd.put;
    assign wdata = i_cmd.shift ? rdata : {r_cost, r_y, r_x};

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act         <= i_s_tuser;
            r_x           <= i_s_tdata[COORD_BITS-1:0];
            r_y           <= i_s_tdata[2*COORD_BITS-1:COORD_BITS];
            r_cost        <= i_s_tdata[EW-1:2*COORD_BITS];
            r_res_x       <= '0;
            r_res_y       <= '0;
            r_res_present <= 1'b0;
            r_res_empty   <= 1'b0;
            r_res_ovf     <= 1'b0;
        end else begin
            if (i_cmd.pop_take) begin
                r_res_x <= rd_x;
                r_res_y <= rd_y;
            end
            if (i_cmd.qry_step && hit_now) begin
                r_res_present <= 1'b1;
            end
            if (i_cmd.set_empty) begin
                r_res_empty <= 1'b1;
            end
            if (i_cmd.set_ovf) begin
                r_res_ovf <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_m_tdata <= OUT_W'({r_res_y, r_res_x});
            r_m_tuser <= {r_res_ovf, r_res_empty, r_res_present};
        end
    end

    // queue control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_occ     <= '0;
            r_k       <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.push_start) begin
                r_k <= r_occ;
            end else if (i_cmd.shift) begin
                r_k <= r_k - CW'(1);
            end else if (i_cmd.qry_start) begin
                r_k    <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.qry_step) begin
                if (r_k < r_occ) begin
                    r_k    <= r_k + CW'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end

            if (i_cmd.put) begin
                r_occ <= r_occ + CW'(1);
            end else if (i_cmd.pop_take) begin
                r_occ <= r_occ - CW'(1);
                if ({1'b0, r_head} == (AW + 1)'(DEPTH - 1)) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_head + AW'(1);
                end
            end

            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.act      = r_act;
        o_sts.empty    = empty;
        o_sts.full     = full;
        o_sts.ge       = (rd_cost >= r_cost);
        o_sts.k_one    = (r_k == CW'(1));
        o_sts.qry_done = hit_now || (!r_pend && (r_k >= r_occ));
        o_sts.out_free = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

@@ rtl/sorted_priority_queue_top.sv @@
// Sorted priority queue of tile coordinates: top level.
//
// Usage: one request word enters on the s_axis channel, its kind on tuser
// (push, pop, query); exactly one result word leaves on m_axis for every
// request. A pop returns the lowest-cost entry's coordinates; among equal
// costs the most recently pushed comes first. Flags on m_axis_tuser mark a
// query hit, a pop of an empty queue, and a push dropped on a full queue.
// Entries live in a circular RAM kept sorted from the head pointer.
// A push moves the stored entries that are not cheaper up one slot, walking
// down from the tail; a query scans from the head until a hit or the end.
// One request is in flight at a time; the next is taken once the result
// has been loaded into the output register, so throughput is set by the
// single RAM read port walking the sorted list.
// Reset empties the queue at once; stored data is not cleared.
// When m_axis_tready is low the result holds in the output register; one
// more request may be accepted and worked, and then waits for the slot.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int COORD_BITS = spq_pkg::COORD_BITS_DEF,
    parameter int COST_BITS  = spq_pkg::COST_BITS_DEF,
    localparam int IN_W  = ((2 * COORD_BITS + COST_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_W-1:0]            s_axis_tdata,  // in_x, in_y, in_priority, zero pad
    input  logic [spq_pkg::ACT_W-1:0]  s_axis_tuser,  // action
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_W-1:0]           m_axis_tdata,  // out_x, out_y, zero pad
    output logic [spq_pkg::FLAG_W-1:0] m_axis_tuser   // present, was_empty, overflow
);
    import spq_pkg::*;

    t_spq_cmd cmd;
    t_spq_sts sts;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    spq_dp #(
        .DEPTH      (DEPTH),
        .COORD_BITS (COORD_BITS),
        .COST_BITS  (COST_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sorted priority queue of tile coordinates.
`timescale 1ns / 1ps

module testbench;

    import spq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int CW    = COORD_BITS_DEF;
    localparam int PW    = COST_BITS_DEF;
    localparam int IN_W  = ((2 * CW + PW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;

    // action code the queue does not act on; it still gets a result word
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    // flag sets as {overflow, was_empty, present}, same order as m_axis_tuser
    localparam logic [FLAG_W-1:0] FLG_NONE  = 3'b000;
    localparam logic [FLAG_W-1:0] FLG_EMPTY = 3'b010;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int ITEMS_PER_RUN = 630;
    localparam int CHUNK         = 105;
    localparam int N_DIR         = 25;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [PW-1:0]    cost;
    } req_t;

    typedef struct packed {
        logic          overflow;
        logic          was_empty;
        logic          present;
        logic [CW-1:0] y;
        logic [CW-1:0] x;
    } reply_t;

    typedef struct packed {
        req_t   req;
        logic   fixed;   // reply typed in below rather than predicted
        reply_t reply;
    } dir_row_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;   // in_x, in_y, in_priority, zero pad
    logic [ACT_W-1:0] s_tuser = '0;   // action
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // out_x, out_y, zero pad
    logic [FLAG_W-1:0] m_tuser;       // present, was_empty, overflow

    sorted_priority_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the sorted list, head at index 0
    logic [CW-1:0] shadow_x    [DEPTH];
    logic [CW-1:0] shadow_y    [DEPTH];
    logic [PW-1:0] shadow_cost [DEPTH];
    int            shadow_count = 0;

    reply_t   replies_due [$];
    dir_row_t dir_tab [N_DIR];
    int       fail_count = 0;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    int       stall_cycles = 0;

    function automatic reply_t apply_queue_op(req_t req);
        reply_t res;
        int     pos;
        int     i;
        res = '0;
        case (req.act)
            ACT_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    res.overflow = 1'b1;
                end else begin
                    // new entry lands ahead of equal costs
                    pos = 0;
                    while (pos < shadow_count && shadow_cost[pos] < req.cost)
                        pos++;
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_x[i]    = shadow_x[i-1];
                        shadow_y[i]    = shadow_y[i-1];
                        shadow_cost[i] = shadow_cost[i-1];
                    end
                    shadow_x[pos]    = req.x;
                    shadow_y[pos]    = req.y;
                    shadow_cost[pos] = req.cost;
                    shadow_count++;
                end
            end
            ACT_POP: begin
                if (shadow_count == 0) begin
                    res.was_empty = 1'b1;
                end else begin
                    res.x = shadow_x[0];
                    res.y = shadow_y[0];
                    for (i = 1; i < shadow_count; i++) begin
                        shadow_x[i-1]    = shadow_x[i];
                        shadow_y[i-1]    = shadow_y[i];
                        shadow_cost[i-1] = shadow_cost[i];
                    end
                    shadow_count--;
                end
            end
            ACT_QUERY: begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_x[i] == req.x && shadow_y[i] == req.y)
                        res.present = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic dir_row_t mk_row(logic [ACT_W-1:0] act, int x, int y, int cost,
                                        logic fixed, int ex, int ey,
                                        logic [FLAG_W-1:0] flags);
        dir_row_t r;
        r.req.act   = act;
        r.req.x     = CW'(x);
        r.req.y     = CW'(y);
        r.req.cost  = PW'(cost);
        r.fixed     = fixed;
        r.reply     = {flags, CW'(ey), CW'(ex)};
        return r;
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        if ($urandom_range(1) == 0)
            return CW'($urandom_range(3));
        return CW'($urandom_range((1 << CW) - 1));
    endfunction

    function automatic req_t random_request(traffic_t mix);
        req_t req;
        int   r;
        int   push_pct;
        int   pop_pct;
        int   idx;
        case (mix)
            MIX_FILL:  begin push_pct = 85; pop_pct = 5;  end
            MIX_DRAIN: begin push_pct = 15; pop_pct = 65; end
            default:   begin push_pct = 40; pop_pct = 30; end
        endcase
        r = $urandom_range(99);
        if (r < push_pct)
            req.act = ACT_PUSH;
        else if (r < push_pct + pop_pct)
            req.act = ACT_POP;
        else if (r < 95)
            req.act = ACT_QUERY;
        else
            req.act = ACT_NONE;
        req.x = pick_coord();
        req.y = pick_coord();
        r = $urandom_range(99);
        if (r < 40)
            req.cost = PW'($urandom_range(7));     // crowd costs to force ties
        else if (r < 45)
            req.cost = '0;
        else if (r < 50)
            req.cost = '1;
        else
            req.cost = PW'($urandom_range((1 << PW) - 1));
        // aim half the queries at a stored entry
        if (req.act == ACT_QUERY && shadow_count > 0 && $urandom_range(1) == 0) begin
            idx   = $urandom_range(shadow_count - 1);
            req.x = shadow_x[idx];
            req.y = shadow_y[idx];
        end
        return req;
    endfunction

    task automatic send_word(req_t req, logic fixed, reply_t fixed_reply);
        logic [IN_W-1:0] word;
        reply_t          predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        word = '0;
        word[CW-1:0]        = req.x;
        word[2*CW-1:CW]     = req.y;
        word[2*CW+PW-1:2*CW] = req.cost;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req.act;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        predicted = apply_queue_op(req);
        replies_due.push_back(fixed ? fixed_reply : predicted);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : rx_side
        reply_t got;
        reply_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tuser[2], m_tuser[1], m_tuser[0], m_tdata[2*CW-1:CW], m_tdata[CW-1:0]};
            if (replies_due.size() == 0) begin
                $error("result word with nothing outstanding");
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("out_x", want.x, got.x);
                check_field("out_y", want.y, got.y);
                check_field("present", want.present, got.present);
                check_field("was_empty", want.was_empty, got.was_empty);
                check_field("overflow", want.overflow, got.overflow);
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int       n;
        req_t     req;
        traffic_t mix;

        dir_tab[0]  = mk_row(ACT_POP,   0,     0,     0,     1, 0, 0, FLG_EMPTY);
        dir_tab[1]  = mk_row(ACT_QUERY, 0,     0,     0,     1, 0, 0, FLG_NONE);
        dir_tab[2]  = mk_row(ACT_NONE,  1023,  1023,  65535, 1, 0, 0, FLG_NONE);
        dir_tab[3]  = mk_row(ACT_PUSH,  1023,  1023,  65535, 1, 0, 0, FLG_NONE);
        dir_tab[4]  = mk_row(ACT_PUSH,  0,     0,     0,     1, 0, 0, FLG_NONE);
        dir_tab[5]  = mk_row(ACT_PUSH,  'h155, 'h2aa, 'h5555, 1, 0, 0, FLG_NONE);
        dir_tab[6]  = mk_row(ACT_PUSH,  'h2aa, 'h155, 'haaaa, 1, 0, 0, FLG_NONE);
        dir_tab[7]  = mk_row(ACT_PUSH,  5,     7,     100,   1, 0, 0, FLG_NONE);
        // equal cost: goes ahead of the entry above
        dir_tab[8]  = mk_row(ACT_PUSH,  9,     9,     100,   1, 0, 0, FLG_NONE);
        dir_tab[9]  = mk_row(ACT_QUERY, 1023,  1023,  0,     0, 0, 0, FLG_NONE);
        dir_tab[10] = mk_row(ACT_QUERY, 1023,  0,     0,     0, 0, 0, FLG_NONE);
        dir_tab[11] = mk_row(ACT_QUERY, 0,     0,     0,     0, 0, 0, FLG_NONE);
        dir_tab[12] = mk_row(ACT_QUERY, 5,     7,     0,     0, 0, 0, FLG_NONE);
        dir_tab[13] = mk_row(ACT_NONE,  5,     7,     3,     1, 0, 0, FLG_NONE);
        dir_tab[14] = mk_row(ACT_POP,   0,     0,     0,     0, 0, 0, FLG_NONE);
        dir_tab[15] = mk_row(ACT_POP,   0,     0,     0,     0, 0, 0, FLG_NONE);
        dir_tab[16] = mk_row(ACT_POP,   0,     0,     0,     0, 0, 0, FLG_NONE);
        // tie at the tail cost
        dir_tab[17] = mk_row(ACT_PUSH,  3,     3,     65535, 1, 0, 0, FLG_NONE);
        dir_tab[18] = mk_row(ACT_POP,   0,     0,     0,     0, 0, 0, FLG_NONE);
        dir_tab[19] = mk_row(ACT_POP,   0,     0,     0,     0, 0, 0, FLG_NONE);
        // only the tail entry is left to match
        dir_tab[20] = mk_row(ACT_POP,   0,     0,     0,     0, 0, 0, FLG_NONE);
        dir_tab[21] = mk_row(ACT_QUERY, 1023,  1023,  0,     0, 0, 0, FLG_NONE);
        dir_tab[22] = mk_row(ACT_POP,   0,     0,     0,     0, 0, 0, FLG_NONE);
        dir_tab[23] = mk_row(ACT_POP,   0,     0,     0,     1, 0, 0, FLG_EMPTY);
        dir_tab[24] = mk_row(ACT_QUERY, 0,     0,     0,     1, 0, 0, FLG_NONE);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            send_word(dir_tab[k].req, dir_tab[k].fixed, dir_tab[k].reply);

        for (int run = 0; run < 3; run++) begin
            case (run)
                0:       begin tx_idle_pct = 6;  rx_idle_pct = 59; end
                1:       begin tx_idle_pct = 59; rx_idle_pct = 6;  end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            n = 0;
            while (n < ITEMS_PER_RUN) begin
                mix = traffic_t'((n / CHUNK) % 3);
                req = random_request(mix);
                send_word(req, 1'b0, '0);
                if (req.act != ACT_NONE)
                    n++;
            end
        end
        s_tvalid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_priority_queue_top.sv
tb/testbench.sv
